// File: design/udg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udg_pkg
// Shared types, protocol constants and the crc-8 byte update for the uart
// register datagram engine.
// ----------------------------------------------------------------------------
package udg_pkg;

    // command codes of an input item
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // read status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SYNC  = 3'd1;
    localparam logic [2:0] ST_BAD_MASTER = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
    localparam logic [2:0] ST_BAD_CRC   = 3'd4;

    // protocol bytes
    localparam logic [7:0] SYNC_BYTE   = 8'h05;
    localparam logic [7:0] MASTER_ADDR = 8'hFF;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    // configuration register indexes
    localparam logic REG_NODE_ADDRESS = 1'b0;
    localparam logic REG_FORCE_ZERO   = 1'b1;

    // work handed from the front to the back
    typedef struct packed {
        logic        kind;       // KIND_TX: send a request datagram, KIND_READ: read result
        logic        is_write;   // request is a write datagram
        logic [6:0]  reg_address;
        logic [7:0]  node;
        logic [31:0] value;      // write value or assembled read value
        logic [2:0]  status;
    } udg_job_t;

    // crc-8 update, byte taken lsb first, register shifting left
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic       top;
        crc = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            top = crc[7];
            crc = {crc[6:0], 1'b0};
            if (top ^ data[k])
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

// File: design/udg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udg_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module udg_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire udg_pkg::udg_job_t push_job,
    output logic                  not_full,
    input  wire logic             pop,
    output logic                  not_empty,
    output udg_pkg::udg_job_t     head_job
);

    udg_pkg::udg_job_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // occupancy
    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_job  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// File: design/udg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udg_front
// Accepts items, turns commands into datagram jobs and checks reply bytes,
// producing a read result job after the eighth reply byte.
// ----------------------------------------------------------------------------
module udg_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [1:0]        mode,
    input  wire logic [6:0]        reg_address,
    input  wire logic [31:0]       write_value,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [7:0]        node,
    output logic                   push,
    output udg_pkg::udg_job_t      push_job
);

    logic        pending_reg, pending_next;
    logic [2:0]  index_reg, index_next;
    logic [7:0]  crc_reg, crc_next;
    logic [6:0]  exp_addr_reg, exp_addr_next;
    logic [31:0] shift_reg, shift_next;
    logic [2:0]  ferr_reg, ferr_next;
    logic [2:0]  final_status;

    // status of a completed reply
    always_comb
    begin
        final_status = ferr_reg;
        if (ferr_reg == udg_pkg::ST_OK && rx_byte != crc_reg)
        begin
            final_status = udg_pkg::ST_BAD_CRC;
        end
    end

    // classify the item and advance the reply checker
    always_comb
    begin
        pending_next  = pending_reg;
        index_next    = index_reg;
        crc_next      = crc_reg;
        exp_addr_next = exp_addr_reg;
        shift_next    = shift_reg;
        ferr_next     = ferr_reg;
        push          = 1'b0;

        push_job.kind        = udg_pkg::KIND_TX;
        push_job.is_write    = (mode == udg_pkg::MODE_WRITE);
        push_job.reg_address = reg_address;
        push_job.node        = node;
        push_job.value       = write_value;
        push_job.status      = udg_pkg::ST_OK;

        if (accept)
        begin
            unique case (mode)
                udg_pkg::MODE_WRITE:
                begin
                    push         = 1'b1;
                    pending_next = 1'b0;
                    index_next   = 3'd0;
                end
                udg_pkg::MODE_READ:
                begin
                    push          = 1'b1;
                    pending_next  = 1'b1;
                    index_next    = 3'd0;
                    crc_next      = 8'h00;
                    exp_addr_next = reg_address;
                    shift_next    = 32'h0;
                    ferr_next     = udg_pkg::ST_OK;
                end
                udg_pkg::MODE_RX:
                begin
                    if (pending_reg)
                    begin
                        if (index_reg == 3'd7)
                        begin
                            push            = 1'b1;
                            push_job.kind   = udg_pkg::KIND_READ;
                            push_job.status = final_status;
                            push_job.value  = (final_status == udg_pkg::ST_OK) ?
                                              shift_reg : 32'h0;
                            pending_next    = 1'b0;
                            index_next      = 3'd0;
                        end
                        else
                        begin
                            if (ferr_reg == udg_pkg::ST_OK)
                            begin
                                if (index_reg == 3'd0 && rx_byte != udg_pkg::SYNC_BYTE)
                                begin
                                    ferr_next = udg_pkg::ST_BAD_SYNC;
                                end
                                else if (index_reg == 3'd1 && rx_byte != udg_pkg::MASTER_ADDR)
                                begin
                                    ferr_next = udg_pkg::ST_BAD_MASTER;
                                end
                                else if (index_reg == 3'd2 && rx_byte != {1'b0, exp_addr_reg})
                                begin
                                    ferr_next = udg_pkg::ST_BAD_ADDR;
                                end
                            end
                            if (index_reg >= 3'd3)
                            begin
                                shift_next = {shift_reg[23:0], rx_byte};
                            end
                            crc_next   = udg_pkg::crc8_feed(crc_reg, rx_byte);
                            index_next = index_reg + 3'd1;
                        end
                    end
                end
                udg_pkg::MODE_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            index_reg    <= 3'd0;
            crc_reg      <= 8'h00;
            exp_addr_reg <= 7'd0;
            shift_reg    <= 32'h0;
            ferr_reg     <= udg_pkg::ST_OK;
        end
        else
        begin
            pending_reg  <= pending_next;
            index_reg    <= index_next;
            crc_reg      <= crc_next;
            exp_addr_reg <= exp_addr_next;
            shift_reg    <= shift_next;
            ferr_reg     <= ferr_next;
        end
    end

endmodule
`default_nettype wire

// File: design/udg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udg_back
// Byte sequencer: walks a datagram job one byte per cycle unless stalled,
// with a running crc, or passes a read result job, into the output register.
// ----------------------------------------------------------------------------
module udg_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    input  wire udg_pkg::udg_job_t job,
    output logic                   job_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_kind,
    output logic [7:0]             tx_byte,
    output logic                   tx_last,
    output logic [31:0]            read_value,
    output logic [2:0]             read_status
);

    udg_pkg::udg_job_t job_reg;
    udg_pkg::udg_job_t cur;
    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg;
    logic [7:0]  crc_reg;
    logic [2:0]  idx;
    logic [7:0]  crc_cur;
    logic [7:0]  data_byte;
    logic        last;
    logic        fire;
    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [31:0] value_reg;
    logic [2:0]  status_reg;

    // current job: the one in progress or the queue head
    assign cur     = busy_reg ? job_reg : job;
    assign idx     = busy_reg ? idx_reg : 3'd0;
    assign crc_cur = busy_reg ? crc_reg : 8'h00;
    assign fire    = (busy_reg || job_valid) && (!valid_reg || out_ready);
    assign job_pop = fire && !busy_reg;

    // datagram byte at the current position
    always_comb
    begin
        unique case (idx)
            3'd0:    data_byte = udg_pkg::SYNC_BYTE;
            3'd1:    data_byte = cur.node;
            3'd2:    data_byte = {cur.is_write, cur.reg_address};
            3'd3:    data_byte = cur.value[31:24];
            3'd4:    data_byte = cur.value[23:16];
            3'd5:    data_byte = cur.value[15:8];
            3'd6:    data_byte = cur.value[7:0];
            default: data_byte = 8'h00;
        endcase
        last = cur.is_write ? (idx == 3'd7) : (idx == 3'd3);
    end

    // sequencing state
    always_comb
    begin
        busy_next = busy_reg;
        if (fire)
        begin
            busy_next = (cur.kind == udg_pkg::KIND_TX) && !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (fire)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // job copy, position, crc and output payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            job_reg <= cur;
            idx_reg <= idx + 3'd1;
            crc_reg <= udg_pkg::crc8_feed(crc_cur, data_byte);
            if (cur.kind == udg_pkg::KIND_READ)
            begin
                kind_reg   <= udg_pkg::KIND_READ;
                byte_reg   <= 8'h00;
                last_reg   <= 1'b0;
                value_reg  <= cur.value;
                status_reg <= cur.status;
            end
            else
            begin
                kind_reg   <= udg_pkg::KIND_TX;
                byte_reg   <= last ? crc_cur : data_byte;
                last_reg   <= last;
                value_reg  <= 32'h0;
                status_reg <= udg_pkg::ST_OK;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign tx_byte     = byte_reg;
    assign tx_last     = last_reg;
    assign read_value  = value_reg;
    assign read_status = status_reg;

endmodule
`default_nettype wire

// File: design/uart_register_datagram_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_register_datagram_engine_unit
// Host side of a single-wire uart register protocol with crc-8 (poly 0x07).
// ----------------------------------------------------------------------------
// A write command produces eight transmit items (sync, node, address with
// bit 7 set, four value bytes msb first, crc) and a read command four
// (sync, node, address, crc); received bytes are checked by the front as
// they are accepted and the eighth reply byte yields one read result item
// with the value and status. The back emits one item per cycle while
// rsp_ready does not hold the output; this byte rate of the back sequencer
// sets throughput, and a two-entry job queue lets new items be taken while
// a datagram is still going out. Configuration sits at byte address 0
// (node_address) and 4 (force_node_zero, reset 1).
// ----------------------------------------------------------------------------
module uart_register_datagram_engine_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // command and received byte items
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [6:0]  reg_address,
    input  wire logic [31:0] write_value,
    input  wire logic [7:0]  rx_byte,
    // result items
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic             out_kind,
    output logic [7:0]       tx_byte,
    output logic             tx_last,
    output logic [31:0]      read_value,
    output logic [2:0]       read_status
);

    logic [7:0]        node_address_reg;
    logic              force_zero_reg;
    logic              cfg_write;
    logic              accept;
    logic [7:0]        node;
    logic              push;
    udg_pkg::udg_job_t push_job;
    logic              q_not_full;
    logic              q_not_empty;
    logic              pop;
    udg_pkg::udg_job_t head_job;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= 8'h00;
            force_zero_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                udg_pkg::REG_NODE_ADDRESS: node_address_reg <= pwdata[7:0];
                udg_pkg::REG_FORCE_ZERO:   force_zero_reg   <= pwdata[0];
                default:                   node_address_reg <= node_address_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[2])
            udg_pkg::REG_NODE_ADDRESS: prdata = {24'h0, node_address_reg};
            udg_pkg::REG_FORCE_ZERO:   prdata = {31'h0, force_zero_reg};
            default:                   prdata = 32'h0;
        endcase
    end

    assign node      = force_zero_reg ? 8'h00 : node_address_reg;
    assign cmd_ready = q_not_full;
    assign accept    = cmd_valid && cmd_ready;

    udg_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .reg_address (reg_address),
        .write_value (write_value),
        .rx_byte     (rx_byte),
        .node        (node),
        .push        (push),
        .push_job    (push_job)
    );

    udg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    udg_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_not_empty),
        .job         (head_job),
        .job_pop     (pop),
        .out_valid   (rsp_valid),
        .out_ready   (rsp_ready),
        .out_kind    (out_kind),
        .tx_byte     (tx_byte),
        .tx_last     (tx_last),
        .read_value  (read_value),
        .read_status (read_status)
    );

endmodule
`default_nettype wire
